// File: hdl/tpem_pkg.sv
// ----------------------------------------------------------------------------
// tpem_pkg
// Shared widths, codes, reset values and control types of the energy meter.
// ----------------------------------------------------------------------------
package tpem_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TICK_BITS   = 48;
  localparam int ENERGY_BITS = 64;

  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int SCALE_BITS     = 16;
  localparam int DEBOUNCE_BITS  = 16;
  localparam int FRAC_BITS      = 16;
  localparam int NUMBER_BITS    = 16;
  localparam int STAMP_BITS     = 48;
  localparam int COUNT_BITS     = 32;
  localparam int SUM_BITS       = 64;

  localparam int PROD_BITS  = 2 * SAMPLE_BITS;
  localparam int POWER_BITS = PROD_BITS + SCALE_BITS + 1;
  localparam int QUOT_BITS  = POWER_BITS - FRAC_BITS;
  localparam int ADD_BITS   = ((ENERGY_BITS > QUOT_BITS) ? ENERGY_BITS : QUOT_BITS) + 1;

  localparam logic signed [CFG_BITS-1:0]      TRIGGER_HIGH_RESET = 16'sd13107;
  localparam logic signed [CFG_BITS-1:0]      TRIGGER_LOW_RESET  = -16'sd13107;
  localparam logic        [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET     = 16'd1;
  localparam logic        [SCALE_BITS-1:0]    POWER_SCALE_RESET  = 16'd1024;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ARMED,
    MODE_TRACE,
    MODE_STOPPING
  } mode_t;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_MUL,
    ST_SCALE,
    ST_COMMIT
  } ctrl_state_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TRIGGER_HIGH,
    CFG_TRIGGER_LOW,
    CFG_DEBOUNCE,
    CFG_POWER_SCALE
  } cfg_index_t;

  typedef enum logic {
    EVENT_START,
    EVENT_END
  } event_kind_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic mul;
    logic scale;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic event_hit;
    logic out_full;
    logic out_taken;
  } dpath_status_t;

endpackage

// File: hdl/tpem_sample_if.sv
// ----------------------------------------------------------------------------
// tpem_sample_if
// Request channel carrying one shunt, supply and trigger sample set.
// ----------------------------------------------------------------------------
interface tpem_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tpem_pkg::SAMPLE_BITS-1:0] shunt_sample;
  logic signed [tpem_pkg::SAMPLE_BITS-1:0] supply_sample;
  logic signed [tpem_pkg::SAMPLE_BITS-1:0] trigger_sample;

  modport source (output valid, output shunt_sample, output supply_sample,
                  output trigger_sample, input ready);
  modport sink   (input valid, input shunt_sample, input supply_sample,
                  input trigger_sample, output ready);
endinterface

// File: hdl/tpem_event_if.sv
// ----------------------------------------------------------------------------
// tpem_event_if
// Request channel carrying one trace start or trace end event.
// ----------------------------------------------------------------------------
interface tpem_event_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   event_kind;
  logic        [tpem_pkg::NUMBER_BITS-1:0] trace_number;
  logic        [tpem_pkg::STAMP_BITS-1:0]  tick_stamp;
  logic        [tpem_pkg::COUNT_BITS-1:0]  trace_samples;
  logic signed [tpem_pkg::SUM_BITS-1:0]    energy_sum;

  modport source (output valid, output event_kind, output trace_number,
                  output tick_stamp, output trace_samples, output energy_sum,
                  input ready);
  modport sink   (input valid, input event_kind, input trace_number,
                  input tick_stamp, input trace_samples, input energy_sum,
                  output ready);
endinterface

// File: hdl/tpem_ctrl.sv
// ----------------------------------------------------------------------------
// tpem_ctrl
// Sequencer: accept, multiply, scale, commit; hold commit while output full.
// ----------------------------------------------------------------------------
module tpem_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  tpem_pkg::dpath_status_t status,
  output tpem_pkg::ctrl_cmd_t     cmd
);

  tpem_pkg::ctrl_state_t state;
  tpem_pkg::ctrl_state_t state_next;
  logic                  stall;

  assign stall = status.event_hit && status.out_full && !status.out_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpem_pkg::ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tpem_pkg::ST_WAIT: begin
        if (in_valid) state_next = tpem_pkg::ST_MUL;
      end
      tpem_pkg::ST_MUL: begin
        state_next = tpem_pkg::ST_SCALE;
      end
      tpem_pkg::ST_SCALE: begin
        state_next = tpem_pkg::ST_COMMIT;
      end
      tpem_pkg::ST_COMMIT: begin
        if (!stall) state_next = tpem_pkg::ST_WAIT;
      end
      default: begin
        state_next = tpem_pkg::ST_WAIT;
      end
    endcase
  end

  always_comb begin
    cmd.ready  = (state == tpem_pkg::ST_WAIT);
    cmd.load   = (state == tpem_pkg::ST_WAIT) && in_valid;
    cmd.mul    = (state == tpem_pkg::ST_MUL);
    cmd.scale  = (state == tpem_pkg::ST_SCALE);
    cmd.commit = (state == tpem_pkg::ST_COMMIT) && !stall;
  end

endmodule

// File: hdl/tpem_dpath.sv
// ----------------------------------------------------------------------------
// tpem_dpath
// Config registers, power multiplier, trace mode, accumulators, event register.
// ----------------------------------------------------------------------------
module tpem_dpath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  tpem_pkg::ctrl_cmd_t                     cmd,
  output tpem_pkg::dpath_status_t                 status,
  input  logic                                    cfg_wr_en,
  input  logic [tpem_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [tpem_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic signed [tpem_pkg::SAMPLE_BITS-1:0] shunt_sample,
  input  logic signed [tpem_pkg::SAMPLE_BITS-1:0] supply_sample,
  input  logic signed [tpem_pkg::SAMPLE_BITS-1:0] trigger_sample,
  tpem_event_if.source                            events
);

  localparam int AB = tpem_pkg::ADD_BITS;
  localparam int EB = tpem_pkg::ENERGY_BITS;
  localparam int CB = tpem_pkg::COUNT_BITS;

  logic signed [tpem_pkg::CFG_BITS-1:0]      trigger_high;
  logic signed [tpem_pkg::CFG_BITS-1:0]      trigger_low;
  logic        [tpem_pkg::DEBOUNCE_BITS-1:0] debounce_count;
  logic        [tpem_pkg::SCALE_BITS-1:0]    power_scale;

  logic signed [tpem_pkg::SAMPLE_BITS-1:0] shunt_r;
  logic signed [tpem_pkg::SAMPLE_BITS-1:0] supply_r;
  logic signed [tpem_pkg::SAMPLE_BITS-1:0] trig_r;
  logic signed [tpem_pkg::PROD_BITS-1:0]   prod_r;
  logic signed [tpem_pkg::POWER_BITS-1:0]  power_r;
  logic signed [tpem_pkg::QUOT_BITS-1:0]   quot;

  tpem_pkg::mode_t                      mode;
  tpem_pkg::mode_t                      mode_next;
  logic [tpem_pkg::DEBOUNCE_BITS-1:0]   high_run;
  logic [tpem_pkg::DEBOUNCE_BITS-1:0]   high_run_next;
  logic [tpem_pkg::DEBOUNCE_BITS:0]     run_inc;
  logic [tpem_pkg::TICK_BITS-1:0]       tick_count;
  logic [tpem_pkg::NUMBER_BITS-1:0]     trace_count;
  logic [CB-1:0]                        sample_count;
  logic [CB-1:0]                        sample_count_next;
  logic [CB-1:0]                        count_base;
  logic signed [EB-1:0]                 energy_acc;
  logic signed [EB-1:0]                 energy_next;
  logic signed [EB-1:0]                 energy_base;
  logic signed [AB-1:0]                 energy_wide;
  logic signed [AB-1:0]                 energy_max;
  logic signed [AB-1:0]                 energy_min;

  logic hi;
  logic lo;
  logic pass;
  logic event_hit;
  logic event_end;
  logic clear_acc;
  logic out_valid;

  assign quot       = power_r[tpem_pkg::POWER_BITS-1:tpem_pkg::FRAC_BITS];
  assign hi         = trig_r > trigger_high;
  assign lo         = trig_r < trigger_low;
  assign run_inc    = {1'b0, high_run} + 1'b1;
  assign pass       = run_inc > {1'b0, debounce_count};
  assign energy_max = AB'(signed'({1'b0, {(EB-1){1'b1}}}));
  assign energy_min = ~energy_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_high   <= tpem_pkg::TRIGGER_HIGH_RESET;
      trigger_low    <= tpem_pkg::TRIGGER_LOW_RESET;
      debounce_count <= tpem_pkg::DEBOUNCE_RESET;
      power_scale    <= tpem_pkg::POWER_SCALE_RESET;
    end else if (cfg_wr_en) begin
      unique case (tpem_pkg::cfg_index_t'(cfg_index))
        tpem_pkg::CFG_TRIGGER_HIGH: trigger_high   <= signed'(cfg_data);
        tpem_pkg::CFG_TRIGGER_LOW:  trigger_low    <= signed'(cfg_data);
        tpem_pkg::CFG_DEBOUNCE:     debounce_count <= cfg_data;
        tpem_pkg::CFG_POWER_SCALE:  power_scale    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shunt_r  <= shunt_sample;
      supply_r <= supply_sample;
      trig_r   <= trigger_sample;
    end
    if (cmd.mul) begin
      prod_r <= shunt_r * supply_r;
    end
    if (cmd.scale) begin
      power_r <= tpem_pkg::POWER_BITS'(prod_r) *
                 tpem_pkg::POWER_BITS'(signed'({1'b0, power_scale}));
    end
  end

  // Trace mode decision for the held sample
  always_comb begin
    mode_next     = mode;
    high_run_next = high_run;
    event_hit     = 1'b0;
    event_end     = 1'b0;
    clear_acc     = 1'b0;
    unique case (mode)
      tpem_pkg::MODE_IDLE: begin
        if (hi) begin
          high_run_next = pass ? '0 : run_inc[tpem_pkg::DEBOUNCE_BITS-1:0];
          if (pass) mode_next = tpem_pkg::MODE_ARMED;
        end
      end
      tpem_pkg::MODE_ARMED: begin
        if (lo) begin
          mode_next     = tpem_pkg::MODE_TRACE;
          high_run_next = '0;
          clear_acc     = 1'b1;
          event_hit     = 1'b1;
        end
      end
      tpem_pkg::MODE_TRACE: begin
        if (hi) begin
          high_run_next = pass ? '0 : run_inc[tpem_pkg::DEBOUNCE_BITS-1:0];
          if (pass) begin
            mode_next = tpem_pkg::MODE_STOPPING;
            event_hit = 1'b1;
            event_end = 1'b1;
          end
        end
      end
      tpem_pkg::MODE_STOPPING: begin
        if (lo) begin
          mode_next     = tpem_pkg::MODE_IDLE;
          high_run_next = '0;
        end
      end
      default: begin
        mode_next = tpem_pkg::MODE_IDLE;
      end
    endcase
  end

  // Saturating accumulation while in trace
  always_comb begin
    energy_base = clear_acc ? '0 : energy_acc;
    count_base  = clear_acc ? '0 : sample_count;
    energy_wide = AB'(energy_base) + AB'(quot);
    energy_next = energy_base;
    sample_count_next = count_base;
    if (mode_next == tpem_pkg::MODE_TRACE) begin
      priority if (energy_wide > energy_max) begin
        energy_next = EB'(energy_max);
      end else if (energy_wide < energy_min) begin
        energy_next = EB'(energy_min);
      end else begin
        energy_next = EB'(energy_wide);
      end
      if (count_base != {CB{1'b1}}) sample_count_next = count_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= tpem_pkg::MODE_IDLE;
      high_run     <= '0;
      tick_count   <= '0;
      trace_count  <= '0;
      sample_count <= '0;
      energy_acc   <= '0;
    end else if (cmd.commit) begin
      mode         <= mode_next;
      high_run     <= high_run_next;
      tick_count   <= tick_count + 1'b1;
      sample_count <= sample_count_next;
      energy_acc   <= energy_next;
      if (event_end) trace_count <= trace_count + 1'b1;
    end
  end

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && event_hit) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && event_hit) begin
      events.event_kind    <= event_end;
      events.trace_number  <= trace_count;
      events.tick_stamp    <= tpem_pkg::STAMP_BITS'(tick_count);
      events.trace_samples <= event_end ? sample_count : '0;
      events.energy_sum    <= event_end ? tpem_pkg::SUM_BITS'(energy_acc) : '0;
    end
  end

  assign events.valid     = out_valid;
  assign status.event_hit = event_hit;
  assign status.out_full  = out_valid;
  assign status.out_taken = events.ready;

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (events.valid && events.event_kind == tpem_pkg::EVENT_START) |->
      (events.trace_samples == '0 && events.energy_sum == '0))
    else $error("start event with non-zero totals");

  a_energy_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(energy_acc))
    else $error("energy sum moved outside commit");

  a_event_source: assert property (@(posedge clk) disable iff (rst)
    $rose(events.valid) |-> $past(cmd.commit))
    else $error("event raised without commit");

endmodule

// File: hdl/triggered_power_trace_energy_meter_top.sv
// ----------------------------------------------------------------------------
// triggered_power_trace_energy_meter_top
// Trigger-framed power trace meter: trace start/end events with energy totals.
// ----------------------------------------------------------------------------
// Sequence: an accepted sample set passes the multiply, scale and commit
//   states and any event is loaded into the event register on commit; a new
//   set waits for commit, held on an event while an earlier one is not taken.
// Reset: synchronous rst clears mode, counters, sums and the event register
//   and loads the configuration reset values.
module triggered_power_trace_energy_meter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tpem_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tpem_pkg::CFG_BITS-1:0]       cfg_data,
  tpem_sample_if.sink                         samples,
  tpem_event_if.source                        events
);

  tpem_pkg::ctrl_cmd_t     cmd;
  tpem_pkg::dpath_status_t status;

  assign samples.ready = cmd.ready;

  tpem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .status   (status),
    .cmd      (cmd)
  );

  tpem_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .shunt_sample   (samples.shunt_sample),
    .supply_sample  (samples.supply_sample),
    .trigger_sample (samples.trigger_sample),
    .events         (events)
  );

endmodule

// File: dv/triggered_power_trace_energy_meter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triggered_power_trace_energy_meter_top_test
// Self-checking bench for the trace energy meter. Sample sets go in through
// the request channel under random gaps and per-sample trigger levels chosen
// from the predicted trace mode. A scoreboard class predicts every start and
// end event and checks each event request field by field, across register
// settings that include the threshold and debounce extremes.
// ----------------------------------------------------------------------------
module triggered_power_trace_energy_meter_top_test;
  import tpem_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 5;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    event_kind_t                    event_kind;
    logic [NUMBER_BITS-1:0]         trace_number;
    logic [STAMP_BITS-1:0]          tick_stamp;
    logic [COUNT_BITS-1:0]          trace_samples;
    logic signed [SUM_BITS-1:0]     energy_sum;
  } meter_event_t;

  typedef enum int { LEVEL_HIGH, LEVEL_LOW, LEVEL_MID } trig_level_t;

  class trace_scoreboard;
    logic signed [CFG_BITS-1:0]    trig_hi;
    logic signed [CFG_BITS-1:0]    trig_lo;
    logic [DEBOUNCE_BITS-1:0]      debounce;
    logic [SCALE_BITS-1:0]         scale;
    mode_t                         mode;
    logic [DEBOUNCE_BITS-1:0]      high_cnt;
    logic [TICK_BITS-1:0]          tick;
    logic [NUMBER_BITS-1:0]        trace_no;
    logic [COUNT_BITS-1:0]         sample_cnt;
    logic signed [ENERGY_BITS-1:0] energy;
    meter_event_t                  event_q[$];
    int                            errors;
    int                            starts_seen;
    int                            ends_seen;
    int                            samples_taken;

    function new();
      trig_hi    = TRIGGER_HIGH_RESET;
      trig_lo    = TRIGGER_LOW_RESET;
      debounce   = DEBOUNCE_RESET;
      scale      = POWER_SCALE_RESET;
      mode       = MODE_IDLE;
      high_cnt   = '0;
      tick       = '0;
      trace_no   = '0;
      sample_cnt = '0;
      energy     = '0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_BITS-1:0] value);
      case (idx)
        CFG_TRIGGER_HIGH: trig_hi  = value;
        CFG_TRIGGER_LOW:  trig_lo  = value;
        CFG_DEBOUNCE:     debounce = value;
        CFG_POWER_SCALE:  scale    = value;
      endcase
    endfunction

    function bit debounce_passed();
      logic [DEBOUNCE_BITS:0] n;
      n = {1'b0, high_cnt} + 1'b1;
      if (n > {1'b0, debounce}) begin
        high_cnt = '0;
        return 1'b1;
      end
      high_cnt = n[DEBOUNCE_BITS-1:0];
      return 1'b0;
    endfunction

    function void push_event(event_kind_t kind);
      meter_event_t ev;
      ev.event_kind    = kind;
      ev.trace_number  = trace_no;
      ev.tick_stamp    = tick[STAMP_BITS-1:0];
      ev.trace_samples = (kind == EVENT_END) ? sample_cnt : '0;
      ev.energy_sum    = (kind == EVENT_END) ? energy : '0;
      event_q.push_back(ev);
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] shunt,
                              logic signed [SAMPLE_BITS-1:0] supply,
                              logic signed [SAMPLE_BITS-1:0] trig);
      bit                            hi;
      bit                            lo;
      longint                        power;
      longint                        share;
      logic signed [ENERGY_BITS:0]   total;
      hi = trig > trig_hi;
      lo = trig < trig_lo;
      samples_taken++;
      case (mode)
        MODE_IDLE: begin
          if (hi && debounce_passed()) mode = MODE_ARMED;
        end
        MODE_ARMED: begin
          if (lo) begin
            mode       = MODE_TRACE;
            sample_cnt = '0;
            energy     = '0;
            high_cnt   = '0;
            push_event(EVENT_START);
          end
        end
        MODE_TRACE: begin
          if (hi && debounce_passed()) begin
            mode = MODE_STOPPING;
            push_event(EVENT_END);
            trace_no = trace_no + 1'b1;
          end
        end
        default: begin
          if (lo) begin
            mode     = MODE_IDLE;
            high_cnt = '0;
          end
        end
      endcase
      if (mode == MODE_TRACE) begin
        power = longint'(shunt) * longint'(supply) * longint'(scale);
        share = power >>> FRAC_BITS;
        total = energy + share;
        if (total[ENERGY_BITS] != total[ENERGY_BITS-1])
          energy = total[ENERGY_BITS] ? {1'b1, {(ENERGY_BITS-1){1'b0}}}
                                      : {1'b0, {(ENERGY_BITS-1){1'b1}}};
        else
          energy = total[ENERGY_BITS-1:0];
        if (sample_cnt != '1) sample_cnt = sample_cnt + 1'b1;
      end
      tick = tick + 1'b1;
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_event(meter_event_t got);
      meter_event_t want;
      if (event_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind %0d trace %0d stamp %0d",
                 $time, got.event_kind, got.trace_number, got.tick_stamp);
        return;
      end
      want = event_q.pop_front();
      compare("event_kind", want.event_kind, got.event_kind);
      compare("trace_number", want.trace_number, got.trace_number);
      compare("tick_stamp", want.tick_stamp, got.tick_stamp);
      compare("trace_samples", want.trace_samples, got.trace_samples);
      compare("energy_sum", want.energy_sum, got.energy_sum);
      if (got.event_kind == EVENT_START) starts_seen++;
      else ends_seen++;
    endfunction

    function int pending();
      return event_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  tpem_sample_if samples_if();
  tpem_event_if  events_if();

  triggered_power_trace_energy_meter_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .events    (events_if)
  );

  trace_scoreboard sb = new();
  int              cycle_count = 0;
  int              hold_request = 0;
  bit              steady = 1'b0;
  int              settings_run = 0;

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic signed [SAMPLE_BITS-1:0] rand_code();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_BITS'(-32768);
      1:       return SAMPLE_BITS'(32767);
      2:       return $urandom_range(0, 1) ? SAMPLE_BITS'(0) : SAMPLE_BITS'(-1);
      default: return SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_trigger(trig_level_t level);
    int lo_b;
    int hi_b;
    case (level)
      LEVEL_HIGH: begin
        if (sb.trig_hi == 32767) return rand_code();
        lo_b = int'(sb.trig_hi) + 1;
        hi_b = 32767;
      end
      LEVEL_LOW: begin
        if (sb.trig_lo == -32768) return rand_code();
        lo_b = -32768;
        hi_b = int'(sb.trig_lo) - 1;
      end
      default: begin
        if (sb.trig_lo > sb.trig_hi) return rand_code();
        lo_b = int'(sb.trig_lo);
        hi_b = int'(sb.trig_hi);
      end
    endcase
    case ($urandom_range(0, 7))
      0:       return SAMPLE_BITS'(lo_b);
      1:       return SAMPLE_BITS'(hi_b);
      default: return SAMPLE_BITS'(lo_b + int'($urandom_range(0, hi_b - lo_b)));
    endcase
  endfunction

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] shunt,
                             logic signed [SAMPLE_BITS-1:0] supply,
                             logic signed [SAMPLE_BITS-1:0] trig);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid          <= 1'b1;
    samples_if.shunt_sample   <= shunt;
    samples_if.supply_sample  <= supply;
    samples_if.trigger_sample <= trig;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    sb.note_sample(shunt, supply, trig);
  endtask

  task automatic random_sample();
    int          pct;
    trig_level_t level;
    pct = $urandom_range(0, 99);
    case (sb.mode)
      MODE_IDLE:  level = (pct < 60) ? LEVEL_HIGH : (pct < 75) ? LEVEL_LOW : LEVEL_MID;
      MODE_ARMED: level = (pct < 40) ? LEVEL_LOW : (pct < 55) ? LEVEL_HIGH : LEVEL_MID;
      MODE_TRACE: level = (pct < 20) ? LEVEL_HIGH : (pct < 40) ? LEVEL_LOW : LEVEL_MID;
      default:    level = (pct < 45) ? LEVEL_LOW : (pct < 60) ? LEVEL_HIGH : LEVEL_MID;
    endcase
    send_sample(rand_code(), rand_code(), rand_trigger(level));
  endtask

  // hold the sender until every predicted event has been taken
  task automatic drain();
    samples_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(int th, int tl, int db, int ps);
    logic [CFG_BITS-1:0] values [4];
    values[0] = CFG_BITS'(th);
    values[1] = CFG_BITS'(tl);
    values[2] = CFG_BITS'(db);
    values[3] = CFG_BITS'(ps);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= values[i];
      @(posedge clk);
      sb.write_reg(cfg_index_t'(i), values[i]);
    end
    cfg_wr_en <= 1'b0;
    settings_run++;
  endtask

  task automatic run_setting(int th, int tl, int db, int ps, int items,
                             int hold, int steady_items, int pause_at);
    drain();
    write_config(th, tl, db, ps);
    hold_request = hold;
    for (int i = 0; i < items; i++) begin
      if (i == pause_at) drain();
      steady = (i < steady_items);
      random_sample();
    end
    steady = 1'b0;
  endtask

  // event receiver: random stalls, one long hold-off on request
  initial begin
    int           stall;
    meter_event_t got;
    events_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        events_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      events_if.ready <= 1'b1;
      @(posedge clk);
      while (!events_if.valid) @(posedge clk);
      got.event_kind    = event_kind_t'(events_if.event_kind);
      got.trace_number  = events_if.trace_number;
      got.tick_stamp    = events_if.tick_stamp;
      got.trace_samples = events_if.trace_samples;
      got.energy_sum    = events_if.energy_sum;
      sb.check_event(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d events outstanding", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst                       <= 1'b1;
    cfg_wr_en                 <= 1'b0;
    cfg_index                 <= '0;
    cfg_data                  <= '0;
    samples_if.valid          <= 1'b0;
    samples_if.shunt_sample   <= '0;
    samples_if.supply_sample  <= '0;
    samples_if.trigger_sample <= '0;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: boundaries, stray samples, cumulative debounce
    send_sample(0, 0, 13107);
    send_sample(1, 1, -32768);
    send_sample(-32768, 32767, 32767);
    send_sample(5, 5, -13107);
    send_sample(7, 7, -20000);
    send_sample(0, 0, 13108);
    send_sample(1, 1, 20000);
    send_sample(-32768, -32768, -13108);
    send_sample(32767, -32768, 0);
    send_sample(-1, 1, 0);
    send_sample(1, 1, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(100, -100, 30000);
    send_sample(3, 3, 25000);
    send_sample(0, 0, -32768);
    drain();

    // zero debounce and full-scale gain
    write_config(13107, -13107, 0, 65535);
    send_sample(-32768, -32768, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 100);
    send_sample(1, -1, 32767);
    send_sample(0, 0, -32768);

    run_setting(13107, -13107, 2, 1024, 500, 600, 0, -1);
    run_setting(32767, -32768, 1, 0, 60, 0, 0, -1);
    run_setting(-32768, 32767, 0, 65535, 150, 0, 0, -1);
    run_setting(0, 0, 3, 65535, 400, 500, 0, 200);
    run_setting(100, -100, 65535, 512, 50, 0, 0, -1);
    run_setting(-2000, 2000, 1, 40000, 300, 0, 0, -1);
    run_setting(20000, -20000, 5, 1024, 440, 0, 200, -1);
    drain();

    $display("Checked %0d sample sets over %0d register settings.",
             sb.samples_taken, settings_run);
    $display("Trace events compared: %0d starts, %0d ends.", sb.starts_seen, sb.ends_seen);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
